// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/brbs_pkg.sv =====
package brbs_pkg;

   localparam int CMD_W   = 4;
   localparam int LEN_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 3;
   localparam int SPAN_W  = 2;
   localparam int CAP_W   = 13;
   localparam int CAP_MIN = 2;
   localparam int POS_MAX = 4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR       = 4'd0,
      CMD_WRITE_BEGIN = 4'd1,
      CMD_WRITE_BYTE  = 4'd2,
      CMD_READ        = 4'd3,
      CMD_PEEK        = 4'd4,
      CMD_MOVE_WRITE  = 4'd5,
      CMD_MOVE_READ   = 4'd6,
      CMD_WRITE_SPAN  = 4'd7,
      CMD_READ_SPAN   = 4'd8
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIZE   = 3'd1,
      ST_RUN_LONG   = 3'd2,
      ST_WRITE_BUSY = 3'd3,
      ST_NO_WRITE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SPAN,
      S_RESP,
      S_SPAN_RESP,
      S_RD_ADDR,
      S_RD_DATA
   } state_type;

   typedef enum logic [1:0] {
      LD_SINGLE,
      LD_SPAN,
      LD_BYTE
   } load_sel_type;

   typedef struct packed {
      logic         capture;
      logic         exec;
      logic         span_step;
      logic         rd_issue;
      logic         out_load;
      load_sel_type out_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic run_go;
      logic span_go;
      logic out_free;
      logic run_last;
   } dp_stat_type;

endpackage

// ===== hw/rtl/brbs_req_if.sv =====
interface brbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [brbs_pkg::CMD_W-1:0]   command;
   logic [brbs_pkg::LEN_W-1:0]   size;
   logic [brbs_pkg::LEN_W-1:0]   max_bytes;
   logic [brbs_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output command, output size, output max_bytes,
                   output in_byte, input ready);
   modport sink   (input valid, input command, input size, input max_bytes,
                   input in_byte, output ready);
endinterface

// ===== hw/rtl/brbs_rsp_if.sv =====
interface brbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [brbs_pkg::STAT_W-1:0]  status;
   logic [brbs_pkg::BYTE_W-1:0]  out_byte;
   logic                         last;
   logic [brbs_pkg::SPAN_W-1:0]  span_count;
   logic [brbs_pkg::LEN_W-1:0]   span0_start;
   logic [brbs_pkg::LEN_W-1:0]   span0_len;
   logic [brbs_pkg::LEN_W-1:0]   span1_len;
   logic [brbs_pkg::LEN_W-1:0]   data_count;
   logic [brbs_pkg::LEN_W-1:0]   free_count;

   modport source (output valid, output status, output out_byte, output last,
                   output span_count, output span0_start, output span0_len,
                   output span1_len, output data_count, output free_count,
                   input ready);
   modport sink   (input valid, input status, input out_byte, input last,
                   input span_count, input span0_start, input span0_len,
                   input span1_len, input data_count, input free_count,
                   output ready);
endinterface

// ===== hw/rtl/byte_ring_buffer_with_spans.sv =====
// Circular byte FIFO with a one-slot gap, holding up to capacity-1 bytes, with
// span queries. One command is taken per transfer on req_ch while the block is
// idle; results leave through an output register on rsp_ch, so the next
// command is taken while a finished result waits. A single-result command is
// accepted, executed and answered; a span query adds a span step; a read or
// peek run issues an address, then loads the output register, for each byte,
// as the single-port byte memory has registered read data; rsp_ch stalls hold
// it. The user must write capacity through csr_wen/csr_wdata only while idle;
// the block does not enforce it. A capacity write is clamped to
// 2..min(DEPTH, 4096) and empties the buffer. The byte memory needs no clearing after reset.
module byte_ring_buffer_with_spans #(
   parameter int DEPTH   = 4096,
   parameter int MAX_RUN = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [brbs_pkg::CAP_W-1:0]  csr_wdata,
   brbs_req_if.sink                    req_ch,
   brbs_rsp_if.source                  rsp_ch
);

   brbs_pkg::ctl_cmd_type ctl_cmd;
   brbs_pkg::dp_stat_type dp_stat;

   brbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd_o     (ctl_cmd),
      .stat_i    (dp_stat)
   );

   brbs_dp #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_command     (req_ch.command),
      .req_size        (req_ch.size),
      .req_max_bytes   (req_ch.max_bytes),
      .req_in_byte     (req_ch.in_byte),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_out_byte    (rsp_ch.out_byte),
      .rsp_last        (rsp_ch.last),
      .rsp_span_count  (rsp_ch.span_count),
      .rsp_span0_start (rsp_ch.span0_start),
      .rsp_span0_len   (rsp_ch.span0_len),
      .rsp_span1_len   (rsp_ch.span1_len),
      .rsp_data_count  (rsp_ch.data_count),
      .rsp_free_count  (rsp_ch.free_count),
      .cmd_i           (ctl_cmd),
      .stat_o          (dp_stat)
   );

endmodule

// ===== hw/rtl/brbs_ctrl.sv =====
`include "assert_macros.svh"

module brbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output brbs_pkg::ctl_cmd_type cmd_o,
   input  brbs_pkg::dp_stat_type stat_i
);

   brbs_pkg::state_type state_ff;
   brbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brbs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brbs_pkg::S_IDLE: begin
            if (req_valid) state_in = brbs_pkg::S_EXEC;
         end
         brbs_pkg::S_EXEC: begin
            if (stat_i.run_go) begin
               state_in = brbs_pkg::S_RD_ADDR;
            end else if (stat_i.span_go) begin
               state_in = brbs_pkg::S_SPAN;
            end else begin
               state_in = brbs_pkg::S_RESP;
            end
         end
         brbs_pkg::S_SPAN: begin
            state_in = brbs_pkg::S_SPAN_RESP;
         end
         brbs_pkg::S_RESP, brbs_pkg::S_SPAN_RESP: begin
            if (stat_i.out_free) state_in = brbs_pkg::S_IDLE;
         end
         brbs_pkg::S_RD_ADDR: begin
            state_in = brbs_pkg::S_RD_DATA;
         end
         brbs_pkg::S_RD_DATA: begin
            // advance to the next byte, or end the run on the last, once this one is handed to the output
            if (stat_i.out_free) begin
               state_in = stat_i.run_last ? brbs_pkg::S_IDLE : brbs_pkg::S_RD_ADDR;
            end
         end
         default: state_in = brbs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd_o     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         brbs_pkg::S_IDLE: begin
            // take no transfer while reset is held
            req_ready     = !reset;
            cmd_o.capture = req_valid && !reset;
         end
         brbs_pkg::S_EXEC: begin
            cmd_o.exec = 1'b1;
         end
         brbs_pkg::S_SPAN: begin
            cmd_o.span_step = 1'b1;
         end
         brbs_pkg::S_RESP: begin
            cmd_o.out_load = stat_i.out_free;
            cmd_o.out_sel  = brbs_pkg::LD_SINGLE;
         end
         brbs_pkg::S_SPAN_RESP: begin
            cmd_o.out_load = stat_i.out_free;
            cmd_o.out_sel  = brbs_pkg::LD_SPAN;
         end
         brbs_pkg::S_RD_ADDR: begin
            cmd_o.rd_issue = 1'b1;
         end
         brbs_pkg::S_RD_DATA: begin
            cmd_o.out_load = stat_i.out_free;
            cmd_o.out_sel  = brbs_pkg::LD_BYTE;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd_o.out_load, stat_i.out_free, "output load while the output register is full")
   `ASSERT_ALWAYS(a_go_exclusive, clock, reset, !(stat_i.run_go && stat_i.span_go), "read run and span query started together")
   `ASSERT_NEXT(a_run_issue, clock, reset, state_ff == brbs_pkg::S_EXEC && stat_i.run_go, cmd_o.rd_issue, "read run did not issue its first access")

endmodule

// ===== hw/rtl/brbs_dp.sv =====
`include "assert_macros.svh"

module brbs_dp #(
   parameter int DEPTH   = 4096,
   parameter int MAX_RUN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [brbs_pkg::CAP_W-1:0]    csr_wdata,
   input  logic [brbs_pkg::CMD_W-1:0]    req_command,
   input  logic [brbs_pkg::LEN_W-1:0]    req_size,
   input  logic [brbs_pkg::LEN_W-1:0]    req_max_bytes,
   input  logic [brbs_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [brbs_pkg::STAT_W-1:0]   rsp_status,
   output logic [brbs_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last,
   output logic [brbs_pkg::SPAN_W-1:0]   rsp_span_count,
   output logic [brbs_pkg::LEN_W-1:0]    rsp_span0_start,
   output logic [brbs_pkg::LEN_W-1:0]    rsp_span0_len,
   output logic [brbs_pkg::LEN_W-1:0]    rsp_span1_len,
   output logic [brbs_pkg::LEN_W-1:0]    rsp_data_count,
   output logic [brbs_pkg::LEN_W-1:0]    rsp_free_count,
   input  brbs_pkg::ctl_cmd_type         cmd_i,
   output brbs_pkg::dp_stat_type         stat_o
);

   localparam int LW        = brbs_pkg::LEN_W;
   localparam int CW        = brbs_pkg::CAP_W;
   localparam int BW        = brbs_pkg::BYTE_W;
   localparam int POS_LIMIT = (DEPTH < brbs_pkg::POS_MAX) ? DEPTH : brbs_pkg::POS_MAX;
   localparam int AW        = $clog2(POS_LIMIT);
   localparam int RUN_W     = $clog2(MAX_RUN + 1);

   localparam logic [CW-1:0] CAP_TOP = CW'(POS_LIMIT);
   localparam logic [CW-1:0] CAP_LOW = CW'(brbs_pkg::CAP_MIN);
   localparam logic [LW-1:0] RUN_TOP = LW'(MAX_RUN);

   function automatic logic [LW-1:0] wrap_add(input logic [LW-1:0] pos,
                                              input logic [LW-1:0] n,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] sum;
      sum = CW'(pos) + CW'(n);
      if (sum >= cap) sum = sum - cap;
      return sum[LW-1:0];
   endfunction

   // storage
   logic [BW-1:0] store_mem [POS_LIMIT];
   logic [BW-1:0] mem_q_ff;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_addr;

   // ring state
   logic [CW-1:0] cap_ff, cap_in;
   logic [LW-1:0] rp_ff, rp_in;
   logic [LW-1:0] wp_ff, wp_in;
   logic          open_ff, open_in;
   logic [LW-1:0] pend_len_ff, pend_len_in;
   logic [LW-1:0] pend_left_ff, pend_left_in;
   logic [LW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LW-1:0] data_ff, data_in;
   logic [LW-1:0] free_ff, free_in;

   // captured request
   logic [brbs_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [LW-1:0]              size_ff, size_in;
   logic [LW-1:0]              maxb_ff, maxb_in;
   logic [BW-1:0]              byte_ff, byte_in;
   brbs_pkg::status_type       status_ff, status_in;

   // read run
   logic [LW-1:0]    rd_addr_ff, rd_addr_in;
   logic [RUN_W-1:0] run_left_ff, run_left_in;

   // span query
   logic [LW-1:0] lim_ff, lim_in;
   logic [LW-1:0] first_ff, first_in;
   logic [LW-1:0] second_ff, second_in;
   logic [LW-1:0] spos_ff, spos_in;
   logic [LW-1:0] l0_ff, l0_in;
   logic [LW-1:0] rem_ff, rem_in;

   // output register
   logic                         o_valid_ff, o_valid_in;
   logic [brbs_pkg::STAT_W-1:0]  o_status_ff, o_status_in;
   logic [BW-1:0]                o_byte_ff, o_byte_in;
   logic                         o_last_ff, o_last_in;
   logic [brbs_pkg::SPAN_W-1:0]  o_cnt_ff, o_cnt_in;
   logic [LW-1:0]                o_s0_ff, o_s0_in;
   logic [LW-1:0]                o_l0_ff, o_l0_in;
   logic [LW-1:0]                o_l1_ff, o_l1_in;
   logic [LW-1:0]                o_data_ff, o_data_in;
   logic [LW-1:0]                o_free_ff, o_free_in;

   logic [CW-1:0] cap_wr;
   logic          is_wspan;
   logic [LW-1:0] span_base;
   logic          bad_w;
   logic          bad_r;
   logic [LW-1:0] l1_val;
   logic          out_free;

   assign out_free = !o_valid_ff || rsp_ready;

   assign cap_wr = (csr_wdata < CAP_LOW) ? CAP_LOW :
                   (csr_wdata > CAP_TOP) ? CAP_TOP : csr_wdata;

   assign bad_w     = (size_ff == '0) || (size_ff > free_ff);
   assign bad_r     = (size_ff == '0) || (size_ff > data_ff);
   assign is_wspan  = (cmd_ff == brbs_pkg::CMD_WRITE_SPAN);
   assign span_base = is_wspan ? free_ff : data_ff;
   assign l1_val    = (second_ff < rem_ff) ? second_ff : rem_ff;
   assign mem_addr  = mem_we ? wr_ptr_ff[AW-1:0] : rd_addr_ff[AW-1:0];

   always_comb begin
      cap_in       = cap_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      open_in      = open_ff;
      pend_len_in  = pend_len_ff;
      pend_left_in = pend_left_ff;
      wr_ptr_in    = wr_ptr_ff;
      data_in      = data_ff;
      free_in      = free_ff;
      cmd_in       = cmd_ff;
      size_in      = size_ff;
      maxb_in      = maxb_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      rd_addr_in   = rd_addr_ff;
      run_left_in  = run_left_ff;
      lim_in       = lim_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      spos_in      = spos_ff;
      l0_in        = l0_ff;
      rem_in       = rem_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      stat_o       = '0;

      if (csr_wen) begin
         cap_in  = cap_wr;
         rp_in   = '0;
         wp_in   = '0;
         open_in = 1'b0;
         data_in = '0;
         free_in = LW'(cap_wr - CW'(1));
      end

      if (cmd_i.capture) begin
         cmd_in  = req_command;
         size_in = req_size;
         maxb_in = req_max_bytes;
         byte_in = req_in_byte;
      end

      if (cmd_i.exec) begin
         status_in = brbs_pkg::ST_OK;
         unique case (cmd_ff) inside
            brbs_pkg::CMD_CLEAR: begin
               rp_in   = '0;
               wp_in   = '0;
               open_in = 1'b0;
               data_in = '0;
               free_in = LW'(cap_ff - CW'(1));
            end
            brbs_pkg::CMD_WRITE_BEGIN: begin
               if (open_ff) begin
                  status_in = brbs_pkg::ST_WRITE_BUSY;
               end else if (bad_w) begin
                  status_in = brbs_pkg::ST_BAD_SIZE;
               end else begin
                  open_in      = 1'b1;
                  pend_len_in  = size_ff;
                  pend_left_in = size_ff;
                  wr_ptr_in    = wp_ff;
               end
            end
            brbs_pkg::CMD_WRITE_BYTE: begin
               if (!open_ff) begin
                  status_in = brbs_pkg::ST_NO_WRITE;
               end else begin
                  mem_we       = 1'b1;
                  wr_ptr_in    = wrap_add(wr_ptr_ff, LW'(1), cap_ff);
                  pend_left_in = pend_left_ff - LW'(1);
                  // commit on the final byte of the open write
                  if (pend_left_ff == LW'(1)) begin
                     wp_in   = wrap_add(wr_ptr_ff, LW'(1), cap_ff);
                     open_in = 1'b0;
                     data_in = data_ff + pend_len_ff;
                     free_in = free_ff - pend_len_ff;
                  end
               end
            end
            brbs_pkg::CMD_READ, brbs_pkg::CMD_PEEK: begin
               if (bad_r) begin
                  status_in = brbs_pkg::ST_BAD_SIZE;
               end else if (size_ff > RUN_TOP) begin
                  status_in = brbs_pkg::ST_RUN_LONG;
               end else begin
                  stat_o.run_go = 1'b1;
                  rd_addr_in    = rp_ff;
                  run_left_in   = size_ff[RUN_W-1:0];
                  if (cmd_ff == brbs_pkg::CMD_READ) begin
                     data_in = data_ff - size_ff;
                     free_in = free_ff + size_ff;
                  end
               end
            end
            brbs_pkg::CMD_MOVE_WRITE: begin
               if (open_ff) begin
                  status_in = brbs_pkg::ST_WRITE_BUSY;
               end else if (bad_w) begin
                  status_in = brbs_pkg::ST_BAD_SIZE;
               end else begin
                  wp_in   = wrap_add(wp_ff, size_ff, cap_ff);
                  data_in = data_ff + size_ff;
                  free_in = free_ff - size_ff;
               end
            end
            brbs_pkg::CMD_MOVE_READ: begin
               if (bad_r) begin
                  status_in = brbs_pkg::ST_BAD_SIZE;
               end else begin
                  rp_in   = wrap_add(rp_ff, size_ff, cap_ff);
                  data_in = data_ff - size_ff;
                  free_in = free_ff + size_ff;
               end
            end
            brbs_pkg::CMD_WRITE_SPAN, brbs_pkg::CMD_READ_SPAN: begin
               if (is_wspan && open_ff) begin
                  status_in = brbs_pkg::ST_WRITE_BUSY;
               end else begin
                  stat_o.span_go = 1'b1;
                  lim_in = ((maxb_ff != '0) && (maxb_ff < span_base)) ? maxb_ff : span_base;
                  if (is_wspan) begin
                     spos_in = wp_ff;
                     if (wp_ff < rp_ff) begin
                        first_in  = rp_ff - wp_ff - LW'(1);
                        second_in = '0;
                     end else begin
                        // the gap slot sits at the end when the reader is at zero
                        first_in  = LW'(cap_ff - CW'(wp_ff) - CW'(rp_ff == '0));
                        second_in = (rp_ff == '0) ? '0 : rp_ff - LW'(1);
                     end
                  end else begin
                     spos_in = rp_ff;
                     if (wp_ff < rp_ff) begin
                        first_in  = LW'(cap_ff - CW'(rp_ff));
                        second_in = wp_ff;
                     end else begin
                        first_in  = '1;
                        second_in = '0;
                     end
                  end
               end
            end
            default: begin
               status_in = brbs_pkg::ST_OK;
            end
         endcase
      end

      if (cmd_i.span_step) begin
         l0_in  = (first_ff < lim_ff) ? first_ff : lim_ff;
         rem_in = lim_ff - ((first_ff < lim_ff) ? first_ff : lim_ff);
      end

      if (cmd_i.rd_issue) begin
         mem_re     = 1'b1;
         rd_addr_in = wrap_add(rd_addr_ff, LW'(1), cap_ff);
      end

      if (cmd_i.out_load && (cmd_i.out_sel == brbs_pkg::LD_BYTE)) begin
         run_left_in = run_left_ff - RUN_W'(1);
         // a consuming read moves the read position once the run is done
         if ((run_left_ff == RUN_W'(1)) && (cmd_ff == brbs_pkg::CMD_READ)) begin
            rp_in = rd_addr_ff;
         end
      end

      stat_o.out_free = out_free;
      stat_o.run_last = (run_left_ff == RUN_W'(1));
   end

   always_comb begin
      o_valid_in  = o_valid_ff && !rsp_ready;
      o_status_in = o_status_ff;
      o_byte_in   = o_byte_ff;
      o_last_in   = o_last_ff;
      o_cnt_in    = o_cnt_ff;
      o_s0_in     = o_s0_ff;
      o_l0_in     = o_l0_ff;
      o_l1_in     = o_l1_ff;
      o_data_in   = o_data_ff;
      o_free_in   = o_free_ff;
      if (cmd_i.out_load) begin
         o_valid_in  = 1'b1;
         o_status_in = status_ff;
         o_byte_in   = '0;
         o_last_in   = 1'b1;
         o_cnt_in    = '0;
         o_s0_in     = '0;
         o_l0_in     = '0;
         o_l1_in     = '0;
         o_data_in   = data_ff;
         o_free_in   = free_ff;
         case (cmd_i.out_sel)
            brbs_pkg::LD_SPAN: begin
               o_status_in = brbs_pkg::ST_OK;
               o_l0_in     = l0_ff;
               o_l1_in     = l1_val;
               o_s0_in     = (l0_ff != '0) ? spos_ff : '0;
               o_cnt_in    = (l1_val != '0) ? 2'd2 : ((l0_ff != '0) ? 2'd1 : 2'd0);
            end
            brbs_pkg::LD_BYTE: begin
               o_status_in = brbs_pkg::ST_OK;
               o_byte_in   = mem_q_ff;
               o_last_in   = (run_left_ff == RUN_W'(1));
            end
            default: begin
               o_status_in = status_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= byte_ff;
      end else if (mem_re) begin
         mem_q_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_TOP;
         rp_ff      <= '0;
         wp_ff      <= '0;
         open_ff    <= 1'b0;
         data_ff    <= '0;
         free_ff    <= LW'(CAP_TOP - CW'(1));
         o_valid_ff <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         open_ff    <= open_in;
         data_ff    <= data_in;
         free_ff    <= free_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_len_ff  <= pend_len_in;
      pend_left_ff <= pend_left_in;
      wr_ptr_ff    <= wr_ptr_in;
      cmd_ff       <= cmd_in;
      size_ff      <= size_in;
      maxb_ff      <= maxb_in;
      byte_ff      <= byte_in;
      status_ff    <= status_in;
      rd_addr_ff   <= rd_addr_in;
      run_left_ff  <= run_left_in;
      lim_ff       <= lim_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      spos_ff      <= spos_in;
      l0_ff        <= l0_in;
      rem_ff       <= rem_in;
      o_status_ff  <= o_status_in;
      o_byte_ff    <= o_byte_in;
      o_last_ff    <= o_last_in;
      o_cnt_ff     <= o_cnt_in;
      o_s0_ff      <= o_s0_in;
      o_l0_ff      <= o_l0_in;
      o_l1_ff      <= o_l1_in;
      o_data_ff    <= o_data_in;
      o_free_ff    <= o_free_in;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_out_byte    = o_byte_ff;
   assign rsp_last        = o_last_ff;
   assign rsp_span_count  = o_cnt_ff;
   assign rsp_span0_start = o_s0_ff;
   assign rsp_span0_len   = o_l0_ff;
   assign rsp_span1_len   = o_l1_ff;
   assign rsp_data_count  = o_data_ff;
   assign rsp_free_count  = o_free_ff;

   `ASSERT_ALWAYS(a_count_sum, clock, reset, CW'(data_ff) + CW'(free_ff) + CW'(1) == cap_ff, "data and free counts do not add up to capacity minus one")
   `ASSERT_ALWAYS(a_pos_range, clock, reset, (CW'(rp_ff) < cap_ff) && (CW'(wp_ff) < cap_ff), "ring position outside capacity")
   `ASSERT_IMPLIES(a_open_left, clock, reset, open_ff, pend_left_ff != '0, "open write with no bytes left")

endmodule
